// ===== rtl/core/lavm_pkg.sv =====
package lavm_pkg;

  // fixed field formats
  localparam int IN_W      = 32;             // Q15.16 coordinates
  localparam int AXIS_W    = 18;             // Q1.16 axis entries
  localparam int TRANS_W   = 32;             // translation terms
  localparam int FRAC_BITS = 16;

  // normalizer: largest magnitude lands in [2^NRM_LO, 2^NRM_HI)
  localparam int NRM_HI    = 30;
  localparam int NRM_LO    = 29;
  localparam int COARSE    = 4;              // coarse shift step
  localparam int MAG_W     = NRM_HI;         // normalized magnitude width
  localparam int SQ_W      = 64;             // sum of squares / root datapath
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int LEN_W     = NRM_HI + 1;     // vector length after scaling
  localparam int QUO_W     = FRAC_BITS + 2;  // quotient bits per component
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef logic signed [AXIS_W-1:0] axis_t;

  localparam axis_t AXIS_ONE = axis_t'(1 << FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_NABS,
    ST_NSHIFT,
    ST_NSQ,
    ST_NSQRT,
    ST_NDIV,
    ST_NEXT,
    ST_DOT,
    ST_ROUND,
    ST_OUT
  } state_t;

  // which vector the normalizer is working on
  typedef enum logic [1:0] {
    PH_FWD,
    PH_RGT,
    PH_UP
  } phase_t;

  // next component index, wrapping 2 -> 0
  function automatic logic [1:0] nxt_idx(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/look_at_view_matrix.sv =====
// Look-at view matrix, one word in, one word out.
// Set words normalize forward, right and up; move words only forward. A zero vector
//   skips the sqrt and divides. Per normalize: 32-step sqrt plus a bit-serial divide
//   per component; products share one multiplier.
// Throughput: one word at a time; next word taken once the result is queued.
// Reset (rst_n low, synchronous): eye/target zero, axes identity, no word held.
module look_at_view_matrix #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_opcode,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_pos_x,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_pos_y,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_pos_z,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_target_x,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_target_y,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_target_z,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_upref_x,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_upref_y,
  input  logic signed [lavm_pkg::IN_W-1:0]      in_upref_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_right_x,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_right_y,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_right_z,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_camup_x,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_camup_y,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_camup_z,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_fwd_x,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_fwd_y,
  output logic signed [lavm_pkg::AXIS_W-1:0]    out_fwd_z,
  output logic signed [lavm_pkg::TRANS_W-1:0]   out_trans_x,
  output logic signed [lavm_pkg::TRANS_W-1:0]   out_trans_y,
  output logic signed [lavm_pkg::TRANS_W-1:0]   out_trans_z
);
  import lavm_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int PW     = (CW > IN_W) ? CW : IN_W;
  localparam int SUM_W  = PW + 2;                       // saturating point adds
  localparam int MUL_W  = PW + 1;                       // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int VEC_W  = (CW + 2 > 52) ? CW + 2 : 52;  // diff or cross vector
  localparam int ACC_W  = (VEC_W > CW + 21) ? VEC_W : CW + 21;
  localparam int RND_W  = ACC_W + 1;

  localparam logic [VEC_W-1:0] SHR4_LIM = VEC_W'(1) << (NRM_HI + COARSE);
  localparam logic [VEC_W-1:0] SHR1_LIM = VEC_W'(1) << NRM_HI;
  localparam logic [VEC_W-1:0] SHL4_LIM = VEC_W'(1) << (NRM_HI - COARSE);
  localparam logic [VEC_W-1:0] SHL1_LIM = VEC_W'(1) << NRM_LO;
  localparam logic [QUO_W-1:0] QONE     = QUO_W'(1) << FRAC_BITS;
  localparam logic [RND_W-1:0] HALF     = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic [RND_W-1:0] TMAX     = (RND_W'(1) << (TRANS_W - 1)) - RND_W'(1);
  localparam logic [RND_W-1:0] TMIN_MAG = RND_W'(1) << (TRANS_W - 1);

  // ---------------------------------------------------------------------
  // input fields as vectors
  // ---------------------------------------------------------------------
  logic signed [IN_W-1:0] pos_in [3];
  logic signed [IN_W-1:0] tgt_in [3];
  logic signed [IN_W-1:0] upr_in [3];

  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_in[2] = in_pos_z;
  assign tgt_in[0] = in_target_x;
  assign tgt_in[1] = in_target_y;
  assign tgt_in[2] = in_target_z;
  assign upr_in[0] = in_upref_x;
  assign upr_in[1] = in_upref_y;
  assign upr_in[2] = in_upref_z;

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  state_t                   state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic                     op_r, op_nxt;
  logic [1:0]               idx_r, idx_nxt;
  logic [4:0]               step_r, step_nxt;

  // camera state
  logic signed [CW-1:0]     eye_r [3], eye_nxt [3];
  logic signed [CW-1:0]     tgt_r [3], tgt_nxt [3];
  axis_t                    rgt_r [3], rgt_nxt [3];
  axis_t                    upx_r [3], upx_nxt [3];
  axis_t                    fwd_r [3], fwd_nxt [3];

  // working registers
  logic signed [IN_W-1:0]   upr_r [3], upr_nxt [3];
  logic signed [VEC_W-1:0]  vec_r [3], vec_nxt [3];
  logic [VEC_W-1:0]         mag_r [3], mag_nxt [3];
  logic                     neg_r [3], neg_nxt [3];
  axis_t                    ovec_r [3], ovec_nxt [3];
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic [SQ_W-1:0]          root_r, root_nxt;
  logic [SQ_W-1:0]          bit_r, bit_nxt;
  logic [LEN_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         nlo_r, nlo_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic signed [TRANS_W-1:0] trans_r [3], trans_nxt [3];

  // output word
  logic                     out_valid_r, out_valid_nxt;
  axis_t                    o_rgt_r [3], o_rgt_nxt [3];
  axis_t                    o_upx_r [3], o_upx_nxt [3];
  axis_t                    o_fwd_r [3], o_fwd_nxt [3];
  logic signed [TRANS_W-1:0] o_trn_r [3], o_trn_nxt [3];

  // combinational temps
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]  ca [3];
  logic signed [MUL_W-1:0]  cb [3];
  axis_t                    dax [3];
  logic [VEC_W-1:0]         mx;
  logic [1:0]               cj, ck;
  logic [SQ_W-1:0]          trial;
  logic [LEN_W-1:0]         len;
  logic [NUM_W-1:0]         num;
  logic [LEN_W:0]           divt;
  logic                     qbit;
  logic [QUO_W-1:0]         qfin;
  logic [ACC_W-1:0]         amag;
  logic [RND_W-1:0]         rr;
  logic signed [ACC_W-1:0]  prod_acc;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[CW-1:0];
    end else if (v < lo) begin
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // largest magnitude for the normalizing shift
  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) begin
      mx = mag_r[1];
    end
    if (mag_r[2] > mx) begin
      mx = mag_r[2];
    end
  end

  // cross operands: upref x fwd for the right axis, fwd x right for up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i] = (phase_r == PH_RGT) ? MUL_W'(upr_r[i]) : MUL_W'(fwd_r[i]);
      cb[i] = (phase_r == PH_RGT) ? MUL_W'(fwd_r[i]) : MUL_W'(rgt_r[i]);
    end
  end

  // dot axis; third term uses the freshly formed forward on a move
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (idx_r)
        2'd0:    dax[i] = rgt_r[i];
        2'd1:    dax[i] = upx_r[i];
        default: dax[i] = (op_r == OP_SET) ? fwd_r[i] : ovec_r[i];
      endcase
    end
  end

  assign cj       = nxt_idx(idx_r);
  assign ck       = nxt_idx(cj);
  assign len      = root_r[LEN_W-1:0];
  assign prod_acc = signed'(prod_r[ACC_W-1:0]);
  assign prod_nxt = mul_a * mul_b;

  // ---------------------------------------------------------------------
  // sequencer: next state and datapath
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    eye_nxt       = eye_r;
    tgt_nxt       = tgt_r;
    rgt_nxt       = rgt_r;
    upx_nxt       = upx_r;
    fwd_nxt       = fwd_r;
    upr_nxt       = upr_r;
    vec_nxt       = vec_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    ovec_nxt      = ovec_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    rem_nxt       = rem_r;
    nlo_nxt       = nlo_r;
    quo_nxt       = quo_r;
    trans_nxt     = trans_r;
    o_rgt_nxt     = o_rgt_r;
    o_upx_nxt     = o_upx_r;
    o_fwd_nxt     = o_fwd_r;
    o_trn_nxt     = o_trn_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);
    mul_a         = '0;
    mul_b         = '0;
    trial         = root_r + bit_r;
    num           = '0;
    divt          = {rem_r, nlo_r[QUO_W-1]};
    qbit          = 1'b0;
    qfin          = '0;
    amag          = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    rr            = (RND_W'(amag) + HALF) >> FRAC_BITS;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt = in_opcode;
          for (int i = 0; i < 3; i++) begin
            if (in_opcode == OP_SET) begin
              eye_nxt[i] = sat_cw(SUM_W'(pos_in[i]));
              tgt_nxt[i] = sat_cw(SUM_W'(tgt_in[i]));
              upr_nxt[i] = upr_in[i];
            end else begin
              eye_nxt[i] = sat_cw(SUM_W'(eye_r[i]) + SUM_W'(pos_in[i]));
              tgt_nxt[i] = sat_cw(SUM_W'(tgt_r[i]) + SUM_W'(pos_in[i]));
            end
            vec_nxt[i] = VEC_W'(tgt_nxt[i]) - VEC_W'(eye_nxt[i]);
          end
          phase_nxt = PH_FWD;
          state_nxt = ST_NABS;
        end
      end

      ST_CROSS: begin
        // c[i] = a[i+1]*b[i+2] - a[i+2]*b[i+1], one product a cycle
        case (step_r)
          5'd0: begin
            mul_a    = ca[cj];
            mul_b    = cb[ck];
            step_nxt = 5'd1;
          end
          5'd1: begin
            acc_nxt  = prod_acc;
            mul_a    = ca[ck];
            mul_b    = cb[cj];
            step_nxt = 5'd2;
          end
          default: begin
            vec_nxt[idx_r] = VEC_W'(acc_r - prod_acc);
            step_nxt       = 5'd0;
            if (idx_r == 2'd2) begin
              idx_nxt   = 2'd0;
              state_nxt = ST_NABS;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        endcase
      end

      ST_NABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_nxt[i] = vec_r[i][VEC_W-1];
          mag_nxt[i] = vec_r[i][VEC_W-1] ? VEC_W'(-vec_r[i]) : VEC_W'(vec_r[i]);
        end
        if (vec_r[0] == '0 && vec_r[1] == '0 && vec_r[2] == '0) begin
          // zero vector normalizes to zero
          for (int i = 0; i < 3; i++) begin
            ovec_nxt[i] = '0;
          end
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_NSHIFT;
        end
      end

      ST_NSHIFT: begin
        if (mx >= SHR4_LIM) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> COARSE;
        end else if (mx >= SHR1_LIM) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else if (mx < SHL4_LIM) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << COARSE;
        end else if (mx < SHL1_LIM) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end else begin
          sq_nxt    = '0;
          step_nxt  = 5'd0;
          state_nxt = ST_NSQ;
        end
      end

      ST_NSQ: begin
        if (step_r != 5'd3) begin
          mul_a = MUL_W'({1'b0, mag_r[step_r[1:0]][MAG_W-1:0]});
          mul_b = MUL_W'({1'b0, mag_r[step_r[1:0]][MAG_W-1:0]});
        end
        if (step_r != 5'd0) begin
          sq_nxt = sq_r + prod_r[SQ_W-1:0];
        end
        if (step_r == 5'd3) begin
          root_nxt  = '0;
          bit_nxt   = SQ_W'(1) << (SQ_W - 2);
          step_nxt  = 5'd0;
          state_nxt = ST_NSQRT;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end

      ST_NSQRT: begin
        // digit-by-digit integer square root, floored
        if (sq_r >= trial) begin
          sq_nxt   = sq_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (step_r == 5'(SQRT_STEPS - 1)) begin
          step_nxt  = 5'd0;
          idx_nxt   = 2'd0;
          state_nxt = ST_NDIV;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end

      ST_NDIV: begin
        // q = (m * 2^F + len/2) / len; top bits of the dividend are below len
        if (step_r == 5'd0) begin
          num      = NUM_W'({mag_r[idx_r][MAG_W-1:0], {FRAC_BITS{1'b0}}})
                     + NUM_W'(len >> 1);
          rem_nxt  = LEN_W'(num[NUM_W-1:QUO_W]);
          nlo_nxt  = num[QUO_W-1:0];
          quo_nxt  = '0;
          step_nxt = 5'd1;
        end else begin
          if (divt >= {1'b0, len}) begin
            rem_nxt = LEN_W'(divt - {1'b0, len});
            qbit    = 1'b1;
          end else begin
            rem_nxt = divt[LEN_W-1:0];
          end
          nlo_nxt = nlo_r << 1;
          quo_nxt = {quo_r[QUO_W-2:0], qbit};
          if (step_r == 5'(QUO_W)) begin
            qfin = (quo_nxt > QONE) ? QONE : quo_nxt;
            ovec_nxt[idx_r] = neg_r[idx_r] ? axis_t'(-qfin) : axis_t'(qfin);
            step_nxt = 5'd0;
            if (idx_r == 2'd2) begin
              idx_nxt   = 2'd0;
              state_nxt = ST_NEXT;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end else begin
            step_nxt = step_r + 5'd1;
          end
        end
      end

      ST_NEXT: begin
        idx_nxt  = 2'd0;
        step_nxt = 5'd0;
        acc_nxt  = '0;
        case (phase_r)
          PH_FWD: begin
            if (op_r == OP_SET) begin
              fwd_nxt   = ovec_r;
              phase_nxt = PH_RGT;
              state_nxt = ST_CROSS;
            end else begin
              state_nxt = ST_DOT;
            end
          end
          PH_RGT: begin
            rgt_nxt   = ovec_r;
            phase_nxt = PH_UP;
            state_nxt = ST_CROSS;
          end
          default: begin
            upx_nxt   = ovec_r;
            state_nxt = ST_DOT;
          end
        endcase
      end

      ST_DOT: begin
        if (step_r != 5'd3) begin
          mul_a = MUL_W'(eye_r[step_r[1:0]]);
          mul_b = MUL_W'(dax[step_r[1:0]]);
        end
        if (step_r != 5'd0) begin
          acc_nxt = acc_r + prod_acc;
        end
        if (step_r == 5'd3) begin
          state_nxt = ST_ROUND;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end

      ST_ROUND: begin
        // round half away from zero, negate, saturate
        if (acc_r[ACC_W-1]) begin
          trans_nxt[idx_r] = (rr > TMAX) ? TRANS_W'(TMAX) : TRANS_W'(rr);
        end else begin
          trans_nxt[idx_r] = (rr > TMIN_MAG) ? TRANS_W'(TMIN_MAG) : TRANS_W'(-rr);
        end
        step_nxt = 5'd0;
        acc_nxt  = '0;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_DOT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          o_rgt_nxt     = rgt_r;
          o_upx_nxt     = upx_r;
          o_fwd_nxt     = fwd_r;
          o_trn_nxt     = trans_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // state register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and camera state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FWD;
      op_r        <= OP_SET;
      idx_r       <= 2'd0;
      step_r      <= 5'd0;
      out_valid_r <= 1'b0;
      eye_r       <= '{'0, '0, '0};
      tgt_r       <= '{'0, '0, '0};
      rgt_r       <= '{AXIS_ONE, axis_t'(0), axis_t'(0)};
      upx_r       <= '{axis_t'(0), AXIS_ONE, axis_t'(0)};
      fwd_r       <= '{axis_t'(0), axis_t'(0), AXIS_ONE};
    end else begin
      phase_r     <= phase_nxt;
      op_r        <= op_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      eye_r       <= eye_nxt;
      tgt_r       <= tgt_nxt;
      rgt_r       <= rgt_nxt;
      upx_r       <= upx_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  // working datapath and output word
  always_ff @(posedge clk) begin
    upr_r   <= upr_nxt;
    vec_r   <= vec_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    ovec_r  <= ovec_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    sq_r    <= sq_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
    rem_r   <= rem_nxt;
    nlo_r   <= nlo_nxt;
    quo_r   <= quo_nxt;
    trans_r <= trans_nxt;
    o_rgt_r <= o_rgt_nxt;
    o_upx_r <= o_upx_nxt;
    o_fwd_r <= o_fwd_nxt;
    o_trn_r <= o_trn_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_right_x = o_rgt_r[0];
  assign out_right_y = o_rgt_r[1];
  assign out_right_z = o_rgt_r[2];
  assign out_camup_x = o_upx_r[0];
  assign out_camup_y = o_upx_r[1];
  assign out_camup_z = o_upx_r[2];
  assign out_fwd_x   = o_fwd_r[0];
  assign out_fwd_y   = o_fwd_r[1];
  assign out_fwd_z   = o_fwd_r[2];
  assign out_trans_x = o_trn_r[0];
  assign out_trans_y = o_trn_r[1];
  assign out_trans_z = o_trn_r[2];

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word taken but block not busy");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NSQRT |-> $onehot(bit_r))
    else $error("sqrt trial bit lost");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NDIV && step_r != 5'd0 |-> rem_r < len)
    else $error("divider remainder not below length");

  a_fwd_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fwd_z <= AXIS_ONE) && (out_fwd_z >= -AXIS_ONE))
    else $error("forward entry exceeds unit");

endmodule

// ===== tb/look_at_view_matrix_tb.sv =====
module look_at_view_matrix_tb;
  import lavm_pkg::*;

  typedef logic signed [IN_W-1:0] coord3_t [3];
  typedef longint vec3_t [3];

  // one expected view matrix: nine axis entries, three translations
  typedef struct {
    logic signed [AXIS_W-1:0]  ax [9];
    logic signed [TRANS_W-1:0] tr [3];
  } view_t;

  localparam int IDLE_LIMIT = 20000;   // cycles with no word moving on either side
  localparam int LONG_HOLD  = 3000;    // receiver hold-off, longer than the block takes for a word
  localparam int TAIL       = 600;     // above the slowest set word

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = OP_SET;
  logic signed [IN_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [IN_W-1:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic signed [IN_W-1:0] in_upref_x = '0, in_upref_y = '0, in_upref_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AXIS_W-1:0] out_right_x, out_right_y, out_right_z;
  logic signed [AXIS_W-1:0] out_camup_x, out_camup_y, out_camup_z;
  logic signed [AXIS_W-1:0] out_fwd_x, out_fwd_y, out_fwd_z;
  logic signed [TRANS_W-1:0] out_trans_x, out_trans_y, out_trans_z;

  look_at_view_matrix u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_target_x(in_target_x), .in_target_y(in_target_y), .in_target_z(in_target_z),
    .in_upref_x(in_upref_x), .in_upref_y(in_upref_y), .in_upref_z(in_upref_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_right_x(out_right_x), .out_right_y(out_right_y), .out_right_z(out_right_z),
    .out_camup_x(out_camup_x), .out_camup_y(out_camup_y), .out_camup_z(out_camup_z),
    .out_fwd_x(out_fwd_x), .out_fwd_y(out_fwd_y), .out_fwd_z(out_fwd_z),
    .out_trans_x(out_trans_x), .out_trans_y(out_trans_y), .out_trans_z(out_trans_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Camera model: own copy of the stored points and axes
  // ---------------------------------------------------------------
  vec3_t cam_eye, cam_tgt, cam_rgt, cam_up, cam_fwd;
  view_t view_q [$];
  int    errors = 0;
  int    n_sets = 0, n_moves = 0, n_checked = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floored integer square root, bit by bit
  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale largest magnitude into [2^29, 2^30), then round(m * 2^16 / len)
  function automatic void unit_vec(input vec3_t v, output vec3_t o);
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    bit neg [3];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = sqrt_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * (64'd1 << FRAC_BITS) + len / 2) / len;
      if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // -dot(eye, axis), rounded ties away from zero, saturated
  function automatic logic signed [TRANS_W-1:0] neg_dot(input vec3_t e, input vec3_t a);
    longint acc, r;
    acc = e[0] * a[0] + e[1] * a[1] + e[2] * a[2];
    r = ((acc < 0 ? -acc : acc) + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (acc < 0) r = -r;
    return TRANS_W'(sat32(-r));
  endfunction

  task automatic camera_reset();
    for (int i = 0; i < 3; i++) begin
      cam_eye[i] = 0; cam_tgt[i] = 0; cam_rgt[i] = 0; cam_up[i] = 0; cam_fwd[i] = 0;
    end
    cam_rgt[0] = 1 << FRAC_BITS;
    cam_up[1]  = 1 << FRAC_BITS;
    cam_fwd[2] = 1 << FRAC_BITS;
  endtask

  // apply one accepted word to the model, queue the matrix it yields
  task automatic predict_view(input logic op, input coord3_t p, input coord3_t t,
                              input coord3_t u);
    vec3_t d, f, upr, tmp;
    view_t v;
    if (op == OP_SET) begin
      for (int i = 0; i < 3; i++) begin
        cam_eye[i] = p[i];
        cam_tgt[i] = t[i];
        upr[i] = u[i];
        d[i] = cam_tgt[i] - cam_eye[i];
      end
      unit_vec(d, cam_fwd);
      cross_prod(upr, cam_fwd, tmp);
      unit_vec(tmp, cam_rgt);
      cross_prod(cam_fwd, cam_rgt, tmp);
      unit_vec(tmp, cam_up);
      f = cam_fwd;
      n_sets++;
    end else begin
      // move: saturating shift of both points, forward used for trans_z only
      for (int i = 0; i < 3; i++) begin
        cam_eye[i] = sat32(cam_eye[i] + longint'(p[i]));
        cam_tgt[i] = sat32(cam_tgt[i] + longint'(p[i]));
        d[i] = cam_tgt[i] - cam_eye[i];
      end
      unit_vec(d, f);
      n_moves++;
    end
    for (int i = 0; i < 3; i++) begin
      v.ax[i]     = AXIS_W'(cam_rgt[i]);
      v.ax[3 + i] = AXIS_W'(cam_up[i]);
      v.ax[6 + i] = AXIS_W'(cam_fwd[i]);
    end
    v.tr[0] = neg_dot(cam_eye, cam_rgt);
    v.tr[1] = neg_dot(cam_eye, cam_up);
    v.tr[2] = neg_dot(cam_eye, f);
    view_q.push_back(v);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
  endtask

  // ---------------------------------------------------------------
  // Monitor: check results against the oldest expectation, then
  // predict from the input word taken at the same edge
  // ---------------------------------------------------------------
  string ax_names [9] = '{"right_x", "right_y", "right_z", "camup_x", "camup_y",
                          "camup_z", "fwd_x", "fwd_y", "fwd_z"};
  string tr_names [3] = '{"trans_x", "trans_y", "trans_z"};

  always @(posedge clk) begin
    view_t want;
    logic signed [AXIS_W-1:0]  got_ax [9];
    logic signed [TRANS_W-1:0] got_tr [3];
    coord3_t p, t, u;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_ax = '{out_right_x, out_right_y, out_right_z, out_camup_x, out_camup_y,
                   out_camup_z, out_fwd_x, out_fwd_y, out_fwd_z};
        got_tr = '{out_trans_x, out_trans_y, out_trans_z};
        if (view_q.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = view_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got_ax[i] !== want.ax[i]) report_mismatch(ax_names[i], got_ax[i], want.ax[i]);
          for (int i = 0; i < 3; i++)
            if (got_tr[i] !== want.tr[i]) report_mismatch(tr_names[i], got_tr[i], want.tr[i]);
        end
        n_checked++;
      end
      if (in_valid && !in_stall) begin
        p = '{in_pos_x, in_pos_y, in_pos_z};
        t = '{in_target_x, in_target_y, in_target_z};
        u = '{in_upref_x, in_upref_y, in_upref_z};
        predict_view(in_opcode, p, t, u);
      end
    end
  end

  // watchdog: cycles with no word moving
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------
  bit rx_idle_en = 1'b0;
  bit long_hold_go = 1'b0;
  int rx_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_go) begin
      long_hold_go = 1'b0;
      rx_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------
  bit tx_idle_en = 1'b0;

  task automatic send_word(input logic op, input coord3_t p, input coord3_t t,
                           input coord3_t u);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    {in_pos_x, in_pos_y, in_pos_z} <= {p[0], p[1], p[2]};
    {in_target_x, in_target_y, in_target_z} <= {t[0], t[1], t[2]};
    {in_upref_x, in_upref_y, in_upref_z} <= {u[0], u[1], u[2]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    go_quiet();
    while (view_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFFFFFF;
          1:       return 32'sh80000000;
          2:       return 32'sh00010000;
          default: return 32'sh0;
        endcase
      end
      2, 3, 4, 5: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                               : -$signed($urandom_range(0, 1 << 20));
      default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 26)
                                           : -$signed($urandom_range(0, 1 << 26));
    endcase
  endfunction

  function automatic coord3_t rand_vec();
    coord3_t v;
    for (int i = 0; i < 3; i++) v[i] = rand_coord();
    return v;
  endfunction

  // set word, with degenerate geometry now and then
  task automatic send_rand_set();
    coord3_t e, t, u;
    e = rand_vec();
    t = ($urandom_range(0, 15) == 0) ? e : rand_vec();
    case ($urandom_range(0, 15))
      0:       u = '{0, 0, 0};
      1:       for (int i = 0; i < 3; i++) u[i] = t[i] - e[i];   // parallel to forward
      2:       for (int i = 0; i < 3; i++) u[i] = e[i] - t[i];
      default: u = rand_vec();
    endcase
    send_word(OP_SET, e, t, u);
  endtask

  // move word: junk in the unused fields, occasional big step to saturate
  task automatic send_rand_move();
    coord3_t d;
    for (int i = 0; i < 3; i++)
      d[i] = ($urandom_range(0, 7) == 0) ? rand_coord() : $signed($urandom_range(0, 1 << 18))
             - (1 << 17);
    send_word(OP_MOVE, d, rand_vec(), rand_vec());
  endtask

  task automatic send_rand_word();
    if ($urandom_range(0, 1)) send_rand_set();
    else send_rand_move();
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    coord3_t z, mx, mn, one;
    z   = '{0, 0, 0};
    mx  = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    mn  = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    one = '{0, 32'sh00010000, 0};
    send_word(OP_MOVE, z, mx, mn);                          // axes straight after reset
    send_word(OP_SET, z, '{0, 0, 32'sh00050000}, one);      // plain camera down +z
    send_word(OP_SET, mn, mx, one);                         // extreme diagonal
    send_word(OP_SET, mx, mn, mx);
    send_word(OP_SET, '{32'sh1234, 32'sh5678, 32'sh9ABC},
              '{32'sh1234, 32'sh5678, 32'sh9ABC}, one);     // eye on target
    send_word(OP_SET, z, '{0, 32'sh00030000, 0}, one);      // up along forward
    send_word(OP_SET, z, '{32'sh00010000, 0, 0}, z);        // zero up
    send_word(OP_SET, '{32'sh00010000, 32'sh00020000, 32'sh00030000},
              '{32'shFFFF0000, 32'sh00040000, 32'sh00100000},
              '{32'sh00000001, 32'sh7FFFFFFF, 32'shFFFFFFFF});
    send_word(OP_MOVE, '{32'sh00010000, 32'shFFFF8000, 32'sh00000001}, mn, mx);
    send_word(OP_MOVE, mx, z, z);                           // eye/target pin high
    send_word(OP_MOVE, mx, z, z);
    send_word(OP_MOVE, mn, z, z);
    send_word(OP_MOVE, mn, z, z);                           // pin low
    send_word(OP_MOVE, mn, z, z);
    send_word(OP_SET, '{32'sh7FFFFFFF, 0, 32'sh80000000},
              '{32'sh80000000, 32'sh7FFFFFFF, 0}, '{0, 0, 32'sh00010000});
    send_word(OP_MOVE, '{32'sh40000000, 32'shC0000000, 32'sh40000000}, z, z);
    wait_drain();
  endtask

  // long receiver hold-off while words keep coming
  task automatic test_backpressure();
    long_hold_go = 1'b1;
    repeat (6) send_rand_word();
    wait_drain();
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      if (k == n / 2) wait_drain();   // sender pause until everything is back
      send_rand_word();
    end
  endtask

  task automatic test_no_idle(input int n);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n) send_rand_word();
    wait_drain();
  endtask

  initial begin
    camera_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1250);
    test_no_idle(150);
    repeat (TAIL) @(posedge clk);
    $display("Covered %0d set and %0d move words, %0d matrices checked", n_sets, n_moves,
             n_checked);
    $display("Degenerate axes, saturating moves, long hold-off and drain pause included");
    if (errors == 0 && view_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, view_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lavm_pkg.sv
rtl/core/look_at_view_matrix.sv
tb/look_at_view_matrix_tb.sv
